[hdl/nls_pkg.sv]
// nls_pkg: shared types and constants of the numeric literal scanner
// state and result structs, radix/kind/special codes, error codes
// no dependencies
`timescale 1ns / 1ps

package nls_pkg;

  localparam int unsigned POSITION_BITS = 16;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam int unsigned OUT_POS_BITS = 16;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_HEX = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_BIG   = 2'd1,
    KIND_FLOAT = 2'd2,
    KIND_FAIL  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SP_NONE   = 2'd0,
    SP_EXP    = 2'd1,
    SP_PERIOD = 2'd2,
    SP_SIGN   = 2'd3
  } special_e;

  localparam logic [4:0] E_NONE             = 5'd0;
  localparam logic [4:0] E_LEADING_ZERO     = 5'd1;
  localparam logic [4:0] E_DIGIT_AFTER_BASE = 5'd2;
  localparam logic [4:0] E_UPPER_BASE       = 5'd3;
  localparam logic [4:0] E_FLOAT_BASE       = 5'd4;
  localparam logic [4:0] E_REPEAT_US        = 5'd5;
  localparam logic [4:0] E_US_AFTER_SPECIAL = 5'd6;
  localparam logic [4:0] E_INVALID_DIGIT    = 5'd7;
  localparam logic [4:0] E_DIGIT_EXPONENT   = 5'd8;
  localparam logic [4:0] E_DUP_PERIOD       = 5'd9;
  localparam logic [4:0] E_DUP_EXPONENT     = 5'd10;
  localparam logic [4:0] E_EXP_AFTER_US     = 5'd11;
  localparam logic [4:0] E_SPECIAL_AFTER_US = 5'd12;
  localparam logic [4:0] E_TRAILING_SPECIAL = 5'd13;
  localparam logic [4:0] E_TRAILING_US      = 5'd14;
  localparam logic [4:0] E_INVALID_CHAR     = 5'd15;
  localparam logic [4:0] E_EXP_SIGN         = 5'd16;

  typedef struct packed {
    logic [POSITION_BITS-1:0] byte_index;
    logic                     first_was_zero;
    radix_e                   radix;
    logic [63:0]              acc;
    logic                     ovf;
    logic                     after_sep;
    logic                     seen_period;
    logic                     seen_exp;
    logic                     float_flag;
    special_e                 last_special;
    logic [4:0]               err;
    logic [POSITION_BITS-1:0] err_pos;
    radix_e                   err_base;
  } scan_st_t;

  typedef struct packed {
    kind_e                   kind;
    radix_e                  base;
    logic [63:0]             value;
    logic [4:0]              code;
    logic [OUT_POS_BITS-1:0] pos;
  } scan_res_t;

  localparam scan_st_t ST_RESET = '{
    byte_index:     '0,
    first_was_zero: 1'b0,
    radix:          RADIX_DEC,
    acc:            64'd0,
    ovf:            1'b0,
    after_sep:      1'b0,
    seen_period:    1'b0,
    seen_exp:       1'b0,
    float_flag:     1'b0,
    last_special:   SP_NONE,
    err:            E_NONE,
    err_pos:        '0,
    err_base:       RADIX_DEC
  };

endpackage

[hdl/numeric_literal_scanner_top.sv]
// numeric_literal_scanner_top: one beat per byte in, one result beat per literal out
// latency: the result is valid the cycle after the last byte is accepted
// throughput: one byte per cycle while the input is not stalled, set by the combinational scan state update
// input is stalled only while a result is held and not being taken
// reset clears the scan state and the result valid; result payload is not reset
// depends on nls_pkg and nls_step
`timescale 1ns / 1ps

module numeric_literal_scanner_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [1:0]  number_base_o,
  output logic [63:0] int_value_o,
  output logic [4:0]  error_code_o,
  output logic [15:0] error_position_o
);
  import nls_pkg::*;

  scan_st_t  state_q, state_d;
  scan_res_t res_d, res_q;
  logic      out_valid_q;
  logic      in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  nls_step u_step (
    .cur_i        (state_q),
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .nxt_o        (state_d),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) state_q <= state_d;
      if (in_fire && last_byte_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && last_byte_i) res_q <= res_d;
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = res_q.kind;
  assign number_base_o    = res_q.base;
  assign int_value_o      = res_q.value;
  assign error_code_o     = res_q.code;
  assign error_position_o = res_q.pos;

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_fire && last_byte_i))
    else $error("result beat without an accepted last byte");

  a_index_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte_i) |=> (state_q.byte_index == '0 && state_q.err == E_NONE))
    else $error("scan state not cleared after last byte");

  a_fail_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((result_kind_o == KIND_FAIL) == (error_code_o != E_NONE)))
    else $error("failure kind and error code disagree");

  a_value_only_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o != KIND_INT) |-> (int_value_o == 64'd0))
    else $error("nonzero value on non-integer result");

endmodule

[hdl/nls_step.sv]
// nls_step: next-state and result logic for one literal byte
// purely combinational; depends on nls_pkg
`timescale 1ns / 1ps

module nls_step (
  input  nls_pkg::scan_st_t  cur_i,
  input  logic [7:0]         byte_value_i,
  input  logic               last_byte_i,
  output nls_pkg::scan_st_t  nxt_o,
  output nls_pkg::scan_res_t res_o
);
  import nls_pkg::*;

  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_O   = 8'h6F;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_UP_O   = 8'h4F;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LO_P   = 8'h70;
  localparam logic [7:0] CH_UP_P   = 8'h50;
  localparam logic [63:0] DEC_LIMIT = 64'h1999_9999_9999_9999;
  localparam logic [POSITION_BITS-1:0] POS_ZERO = '0;
  localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_TWO  = POSITION_BITS'(2);

  function automatic logic [5:0] radix_limit(radix_e r);
    logic [5:0] v;
    case (r)
      RADIX_BIN: v = 6'd2;
      RADIX_OCT: v = 6'd8;
      RADIX_HEX: v = 6'd16;
      default:   v = 6'd10;
    endcase
    return v;
  endfunction

  function automatic scan_st_t latch_err(scan_st_t s, logic [4:0] code,
                                         logic [POSITION_BITS-1:0] pos, radix_e base);
    scan_st_t r;
    r = s;
    if (s.err == E_NONE) begin
      r.err      = code;
      r.err_pos  = pos;
      r.err_base = base;
    end
    return r;
  endfunction

  // constant-radix multiply-accumulate with overflow detect
  function automatic scan_st_t mac(scan_st_t s, logic [5:0] digit);
    scan_st_t    r;
    logic        hi;
    logic [63:0] prod;
    logic [64:0] sum;
    r = s;
    case (s.radix)
      RADIX_BIN: begin
        hi   = s.acc[63];
        prod = {s.acc[62:0], 1'b0};
      end
      RADIX_OCT: begin
        hi   = |s.acc[63:61];
        prod = {s.acc[60:0], 3'b000};
      end
      RADIX_HEX: begin
        hi   = |s.acc[63:60];
        prod = {s.acc[59:0], 4'b0000};
      end
      default: begin
        hi   = s.acc > DEC_LIMIT;
        prod = {s.acc[60:0], 3'b000} + {s.acc[62:0], 1'b0};
      end
    endcase
    sum   = {1'b0, prod} + 65'(digit);
    r.acc = sum[63:0];
    if (hi || sum[64]) r.ovf = 1'b1;
    return r;
  endfunction

  function automatic scan_st_t scan_byte(scan_st_t s, logic [7:0] c,
                                         logic [POSITION_BITS-1:0] pos);
    scan_st_t   r;
    logic       is_exp;
    logic       is_alnum;
    logic [5:0] digit;
    r        = s;
    is_exp   = ((c == CH_LO_E || c == CH_UP_E) && s.radix == RADIX_DEC) ||
               ((c == CH_LO_P || c == CH_UP_P) && s.radix == RADIX_HEX);
    is_alnum = 1'b1;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      digit = 6'(c - CH_ZERO);
    end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
      digit = 6'(c - CH_UP_A + 8'd10);
    end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
      digit = 6'(c - CH_LO_A + 8'd10);
    end else begin
      digit    = 6'd0;
      is_alnum = 1'b0;
    end

    if (c == CH_US) begin
      if ((pos == POS_TWO && s.radix != RADIX_DEC) || s.last_special != SP_NONE) begin
        r = latch_err(r, E_US_AFTER_SPECIAL, pos, RADIX_DEC);
      end else if (s.after_sep) begin
        r = latch_err(r, E_REPEAT_US, pos, RADIX_DEC);
      end else begin
        r.after_sep = 1'b1;
      end
    end else if (is_exp) begin
      r.float_flag = 1'b1;
      if (s.seen_exp) begin
        r = latch_err(r, E_DUP_EXPONENT, pos, RADIX_DEC);
      end else if (s.after_sep) begin
        r = latch_err(r, E_EXP_AFTER_US, pos, RADIX_DEC);
      end else begin
        r.last_special = SP_EXP;
        r.seen_exp     = 1'b1;
      end
    end else if (c == CH_DOT) begin
      r.float_flag = 1'b1;
      if (s.radix == RADIX_BIN || s.radix == RADIX_OCT) begin
        r = latch_err(r, E_FLOAT_BASE, POS_TWO, RADIX_DEC);
      end else if (s.seen_period) begin
        r = latch_err(r, E_DUP_PERIOD, pos, RADIX_DEC);
      end else begin
        r.seen_period = 1'b1;
        if (s.after_sep) begin
          r = latch_err(r, E_SPECIAL_AFTER_US, pos, RADIX_DEC);
        end else begin
          r.last_special = SP_PERIOD;
        end
      end
    end else if (c inside {CH_PLUS, CH_MINUS}) begin
      if (s.last_special != SP_EXP) begin
        r = latch_err(r, E_EXP_SIGN, pos, RADIX_DEC);
      end else begin
        r.last_special = SP_SIGN;
      end
    end else if (!is_alnum) begin
      r = latch_err(r, E_INVALID_CHAR, pos, RADIX_DEC);
    end else if (digit >= radix_limit(s.radix)) begin
      r = latch_err(r, E_INVALID_DIGIT, pos, s.radix);
    end else if (s.seen_exp && digit >= 6'd10) begin
      r = latch_err(r, E_DIGIT_EXPONENT, pos, RADIX_DEC);
    end else begin
      r.after_sep    = 1'b0;
      r.last_special = SP_NONE;
      if (!s.float_flag) r = mac(r, digit);
    end
    return r;
  endfunction

  scan_st_t                 st;
  scan_st_t                 fin;
  logic [POSITION_BITS-1:0] pos;

  always_comb begin
    pos = cur_i.byte_index;
    st  = cur_i;
    if (cur_i.err == E_NONE) begin
      if (pos == POS_ZERO) begin
        st.first_was_zero = (byte_value_i == CH_ZERO);
        st = scan_byte(st, byte_value_i, pos);
      end else if (pos == POS_ONE && cur_i.first_was_zero) begin
        case (byte_value_i)
          CH_LO_B: st.radix = RADIX_BIN;
          CH_LO_O: st.radix = RADIX_OCT;
          CH_LO_X: st.radix = RADIX_HEX;
          CH_UP_B, CH_UP_O, CH_UP_X: st = latch_err(st, E_UPPER_BASE, POS_ONE, RADIX_DEC);
          CH_DOT, CH_LO_E, CH_UP_E:  st = scan_byte(st, byte_value_i, pos);
          default: st = latch_err(st, E_LEADING_ZERO, POS_ZERO, RADIX_DEC);
        endcase
        if (st.radix != RADIX_DEC && last_byte_i) begin
          st = latch_err(st, E_DIGIT_AFTER_BASE, POS_TWO, RADIX_DEC);
        end
      end else begin
        st = scan_byte(st, byte_value_i, pos);
      end
    end
    if (cur_i.byte_index < POS_MAX) st.byte_index = cur_i.byte_index + POS_ONE;

    // end-of-literal checks
    fin = st;
    if (st.err == E_NONE) begin
      if (st.after_sep) begin
        fin = latch_err(st, E_TRAILING_US, pos, RADIX_DEC);
      end else if (st.last_special != SP_NONE) begin
        fin = latch_err(st, E_TRAILING_SPECIAL, pos, RADIX_DEC);
      end
    end

    res_o.value = 64'd0;
    res_o.code  = E_NONE;
    res_o.pos   = '0;
    res_o.base  = fin.radix;
    if (fin.err != E_NONE) begin
      res_o.kind = KIND_FAIL;
      res_o.base = fin.err_base;
      res_o.code = fin.err;
      res_o.pos  = OUT_POS_BITS'(fin.err_pos);
    end else if (fin.float_flag) begin
      res_o.kind = KIND_FLOAT;
    end else if (fin.ovf) begin
      res_o.kind = KIND_BIG;
    end else begin
      res_o.kind  = KIND_INT;
      res_o.value = fin.acc;
    end

    nxt_o = last_byte_i ? ST_RESET : st;
  end

endmodule

[tb/numeric_literal_scanner_top_tb.sv]
// numeric_literal_scanner_top_tb: self-checking bench for the numeric literal scanner
// directed literal table, then random literals with bursty input and a stalling receiver
// depends on nls_pkg and numeric_literal_scanner_top
`timescale 1ns / 1ps

module numeric_literal_scanner_top_tb;
  import nls_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_BYTES = 1240;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_value_i = 8'd0;
  logic        last_byte_i  = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [1:0]  result_kind_o;
  logic [1:0]  number_base_o;
  logic [63:0] int_value_o;
  logic [4:0]  error_code_o;
  logic [15:0] error_position_o;

  numeric_literal_scanner_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .byte_value_i     (byte_value_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .number_base_o    (number_base_o),
    .int_value_o      (int_value_o),
    .error_code_o     (error_code_o),
    .error_position_o (error_position_o)
  );

  always #10 clk_i = ~clk_i;

  // scanner state as predicted
  logic [POSITION_BITS-1:0] sc_index;
  bit                       sc_lead_zero;
  radix_e                   sc_radix;
  logic [63:0]              sc_acc;
  bit                       sc_ovf;
  bit                       sc_sep;
  bit                       sc_period;
  bit                       sc_exp;
  bit                       sc_float;
  special_e                 sc_special;
  logic [4:0]               sc_err;
  logic [POSITION_BITS-1:0] sc_err_pos;
  radix_e                   sc_err_radix;

  scan_res_t   pending_results[$];
  logic [7:0]  gen_buf[$];
  string       row_text[$];
  bit          row_typed[$];
  scan_res_t   row_want[$];
  bit          use_typed = 1'b0;
  scan_res_t   typed_want;
  int unsigned burst_left = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned rcv_tick = 0;
  int unsigned rcv_mode = 0;

  function automatic int unsigned radix_weight(radix_e r);
    case (r)
      RADIX_BIN: return 2;
      RADIX_OCT: return 8;
      RADIX_HEX: return 16;
      default:   return 10;
    endcase
  endfunction

  task automatic append_byte(logic [7:0] b);
    gen_buf.insert(gen_buf.size(), b);
  endtask

  task automatic lex_clear();
    sc_index     = '0;
    sc_lead_zero = 1'b0;
    sc_radix     = RADIX_DEC;
    sc_acc       = 64'd0;
    sc_ovf       = 1'b0;
    sc_sep       = 1'b0;
    sc_period    = 1'b0;
    sc_exp       = 1'b0;
    sc_float     = 1'b0;
    sc_special   = SP_NONE;
    sc_err       = E_NONE;
    sc_err_pos   = '0;
    sc_err_radix = RADIX_DEC;
  endtask

  task automatic flag_error(logic [4:0] code, logic [POSITION_BITS-1:0] p, radix_e b);
    if (sc_err == E_NONE) begin
      sc_err       = code;
      sc_err_pos   = p;
      sc_err_radix = b;
    end
  endtask

  task automatic scan_char(logic [7:0] c, logic [POSITION_BITS-1:0] p);
    int unsigned rv;
    int unsigned dig;
    logic [67:0] prod;
    logic [64:0] sum;
    rv = radix_weight(sc_radix);
    if (c == "_") begin
      if ((p == 2 && sc_radix != RADIX_DEC) || sc_special != SP_NONE)
        flag_error(E_US_AFTER_SPECIAL, p, RADIX_DEC);
      else if (sc_sep)
        flag_error(E_REPEAT_US, p, RADIX_DEC);
      else
        sc_sep = 1'b1;
      return;
    end
    if (((c == "e" || c == "E") && sc_radix == RADIX_DEC) ||
        ((c == "p" || c == "P") && sc_radix == RADIX_HEX)) begin
      sc_float = 1'b1;
      if (sc_exp)
        flag_error(E_DUP_EXPONENT, p, RADIX_DEC);
      else if (sc_sep)
        flag_error(E_EXP_AFTER_US, p, RADIX_DEC);
      else begin
        sc_special = SP_EXP;
        sc_exp     = 1'b1;
      end
      return;
    end
    if (c == ".") begin
      sc_float = 1'b1;
      if (sc_radix == RADIX_BIN || sc_radix == RADIX_OCT)
        flag_error(E_FLOAT_BASE, 2, RADIX_DEC);
      else if (sc_period)
        flag_error(E_DUP_PERIOD, p, RADIX_DEC);
      else begin
        sc_period = 1'b1;
        if (sc_sep)
          flag_error(E_SPECIAL_AFTER_US, p, RADIX_DEC);
        else
          sc_special = SP_PERIOD;
      end
      return;
    end
    if (c == "+" || c == "-") begin
      if (sc_special != SP_EXP)
        flag_error(E_EXP_SIGN, p, RADIX_DEC);
      else
        sc_special = SP_SIGN;
      return;
    end
    if (c >= "0" && c <= "9")
      dig = c - "0";
    else if (c >= "A" && c <= "Z")
      dig = c - "A" + 10;
    else if (c >= "a" && c <= "z")
      dig = c - "a" + 10;
    else begin
      flag_error(E_INVALID_CHAR, p, RADIX_DEC);
      return;
    end
    if (dig >= rv) begin
      flag_error(E_INVALID_DIGIT, p, sc_radix);
      return;
    end
    if (sc_exp && dig >= 10) begin
      flag_error(E_DIGIT_EXPONENT, p, RADIX_DEC);
      return;
    end
    sc_sep     = 1'b0;
    sc_special = SP_NONE;
    if (!sc_float) begin
      prod = sc_acc * rv;
      if (prod[67:64] != 4'd0)
        sc_ovf = 1'b1;
      sum = prod[63:0] + dig;
      if (sum[64])
        sc_ovf = 1'b1;
      sc_acc = sum[63:0];
    end
  endtask

  task automatic lex_byte(input logic [7:0] c, input bit last, output bit emit,
                          output scan_res_t r);
    logic [POSITION_BITS-1:0] p;
    p    = sc_index;
    emit = 1'b0;
    r    = '0;
    if (sc_err == E_NONE) begin
      if (p == 0) begin
        sc_lead_zero = (c == "0");
        scan_char(c, p);
      end else if (p == 1 && sc_lead_zero) begin
        case (c)
          "b":           sc_radix = RADIX_BIN;
          "o":           sc_radix = RADIX_OCT;
          "x":           sc_radix = RADIX_HEX;
          "B", "O", "X": flag_error(E_UPPER_BASE, 1, RADIX_DEC);
          ".", "e", "E": scan_char(c, p);
          default:       flag_error(E_LEADING_ZERO, 0, RADIX_DEC);
        endcase
        if (sc_radix != RADIX_DEC && last)
          flag_error(E_DIGIT_AFTER_BASE, 2, RADIX_DEC);
      end else begin
        scan_char(c, p);
      end
    end
    if (sc_index != POS_MAX)
      sc_index++;
    if (!last)
      return;
    emit = 1'b1;
    if (sc_err == E_NONE) begin
      if (sc_sep)
        flag_error(E_TRAILING_US, p, RADIX_DEC);
      else if (sc_special != SP_NONE)
        flag_error(E_TRAILING_SPECIAL, p, RADIX_DEC);
    end
    r.base  = sc_radix;
    r.value = 64'd0;
    r.code  = E_NONE;
    r.pos   = '0;
    if (sc_err != E_NONE) begin
      r.kind = KIND_FAIL;
      r.base = sc_err_radix;
      r.code = sc_err;
      r.pos  = OUT_POS_BITS'(sc_err_pos);
    end else if (sc_float) begin
      r.kind = KIND_FLOAT;
    end else if (sc_ovf) begin
      r.kind = KIND_BIG;
    end else begin
      r.kind  = KIND_INT;
      r.value = sc_acc;
    end
    lex_clear();
  endtask

  task automatic send_byte(input logic [7:0] c, input bit last);
    bit        emit;
    scan_res_t r;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    byte_value_i <= c;
    last_byte_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    lex_byte(c, last, emit, r);
    if (emit)
      pending_results.insert(pending_results.size(), use_typed ? typed_want : r);
  endtask

  task automatic send_buf();
    for (int i = 0; i < gen_buf.size(); i++)
      send_byte(gen_buf[i], i == gen_buf.size() - 1);
  endtask

  task automatic add_checked(string s, kind_e k, radix_e b, logic [63:0] v,
                             logic [4:0] code, logic [15:0] p);
    scan_res_t w;
    w.kind  = k;
    w.base  = b;
    w.value = v;
    w.code  = code;
    w.pos   = p;
    row_text.insert(row_text.size(), s);
    row_typed.insert(row_typed.size(), 1'b1);
    row_want.insert(row_want.size(), w);
  endtask

  task automatic add_predicted(string s);
    row_text.insert(row_text.size(), s);
    row_typed.insert(row_typed.size(), 1'b0);
    row_want.insert(row_want.size(), '0);
  endtask

  function automatic logic [7:0] digit_char(radix_e r, bit nonzero);
    int unsigned v;
    logic [7:0]  ch;
    v = $urandom_range(nonzero ? 1 : 0, radix_weight(r) - 1);
    if (v < 10)
      ch = "0" + v;
    else
      ch = ($urandom_range(0, 1) ? "a" : "A") + v - 10;
    return ch;
  endfunction

  task automatic add_digits(radix_e r, int unsigned n, bit nonzero_first);
    for (int unsigned i = 0; i < n; i++) begin
      append_byte(digit_char(r, i == 0 && nonzero_first));
      if (i + 1 < n && $urandom_range(0, 7) == 0)
        append_byte("_");
    end
  endtask

  // mostly well-formed literals, some with one corrupted byte, some pure noise
  task automatic build_literal();
    string       junk;
    int unsigned sel;
    int unsigned n;
    int unsigned at;
    bit          has_mant;
    logic [7:0]  b;
    radix_e      r;
    junk = "_.eEpP+-bBoOxX09afz#";
    gen_buf.delete();
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      repeat ($urandom_range(1, 6)) begin
        b = $urandom_range(0, 255);
        append_byte(b);
      end
      return;
    end
    r = radix_e'($urandom_range(0, 3));
    n = $urandom_range(1, 6);
    if ($urandom_range(0, 7) == 0) begin
      case (r)
        RADIX_BIN: n = $urandom_range(60, 70);
        RADIX_OCT: n = $urandom_range(20, 25);
        RADIX_HEX: n = $urandom_range(14, 18);
        default:   n = $urandom_range(17, 24);
      endcase
    end
    has_mant = 1'b1;
    if (r == RADIX_DEC) begin
      if ($urandom_range(0, 9) == 0)
        append_byte("0");
      else
        add_digits(r, n, 1'b1);
    end else begin
      append_byte("0");
      append_byte(r == RADIX_BIN ? "b" : (r == RADIX_OCT ? "o" : "x"));
      has_mant = ($urandom_range(0, 19) != 0);
      if (has_mant)
        add_digits(r, n, 1'b0);
    end
    if (has_mant && (r == RADIX_DEC || r == RADIX_HEX) && $urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1)) begin
        append_byte(".");
        add_digits(r, $urandom_range(1, 4), 1'b0);
      end
      if ($urandom_range(0, 1)) begin
        if (r == RADIX_DEC)
          append_byte($urandom_range(0, 1) ? "e" : "E");
        else
          append_byte($urandom_range(0, 1) ? "p" : "P");
        if ($urandom_range(0, 1))
          append_byte($urandom_range(0, 1) ? "+" : "-");
        add_digits(RADIX_DEC, $urandom_range(1, 3), 1'b0);
      end
    end
    if (sel < 40) begin
      at = $urandom_range(0, gen_buf.size() - 1);
      b  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                       : junk[$urandom_range(0, junk.len() - 1)];
      case ($urandom_range(0, 2))
        0: gen_buf[at] = b;
        1: gen_buf.insert(at, b);
        default: if (gen_buf.size() > 1) gen_buf.delete(at);
      endcase
    end
  endtask

  // receiver stall pattern, in one of four modes picked at random into rcv_mode
  always @(posedge clk_i) begin
    rcv_tick++;
    if (rcv_tick % 64 == 0)
      rcv_mode = $urandom_range(0, 3);
    case (rcv_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= (rcv_tick % 4 != 0);
      2:       out_ready_i <= $urandom_range(0, 1);
      default: out_ready_i <= (rcv_tick % 16 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    scan_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: kind %0d base %0d value %h code %0d pos %0d",
                   result_kind_o, number_base_o, int_value_o, error_code_o,
                   error_position_o);
      end else begin
        want = pending_results.pop_front();
        if (result_kind_o !== want.kind || number_base_o !== want.base ||
            int_value_o !== want.value || error_code_o !== want.code ||
            error_position_o !== want.pos) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch: expected kind %0d base %0d value %h code %0d pos %0d, ",
                      "got kind %0d base %0d value %h code %0d pos %0d"},
                     want.kind, want.base, want.value, want.code, want.pos,
                     result_kind_o, number_base_o, int_value_o, error_code_o,
                     error_position_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL numeric_literal_scanner_top");
      $finish;
    end
  end

  initial begin
    int unsigned random_sent;
    random_sent = 0;
    lex_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_checked("0", KIND_INT, RADIX_DEC, 64'd0, E_NONE, 16'd0);
    add_checked("18446744073709551615", KIND_INT, RADIX_DEC, '1, E_NONE, 16'd0);
    add_checked("18446744073709551616", KIND_BIG, RADIX_DEC, 64'd0, E_NONE, 16'd0);
    add_checked("0xffffffffffffffff", KIND_INT, RADIX_HEX, '1, E_NONE, 16'd0);
    add_checked("0b1011", KIND_INT, RADIX_BIN, 64'd11, E_NONE, 16'd0);
    add_checked("00", KIND_FAIL, RADIX_DEC, 64'd0, E_LEADING_ZERO, 16'd0);
    add_checked("0x", KIND_FAIL, RADIX_DEC, 64'd0, E_DIGIT_AFTER_BASE, 16'd2);
    add_checked("0o", KIND_FAIL, RADIX_DEC, 64'd0, E_DIGIT_AFTER_BASE, 16'd2);
    add_checked("0X1", KIND_FAIL, RADIX_DEC, 64'd0, E_UPPER_BASE, 16'd1);
    add_checked("0b1.1", KIND_FAIL, RADIX_DEC, 64'd0, E_FLOAT_BASE, 16'd2);
    add_checked("1__2", KIND_FAIL, RADIX_DEC, 64'd0, E_REPEAT_US, 16'd2);
    add_checked("0x_1", KIND_FAIL, RADIX_DEC, 64'd0, E_US_AFTER_SPECIAL, 16'd2);
    add_checked("0b102", KIND_FAIL, RADIX_BIN, 64'd0, E_INVALID_DIGIT, 16'd4);
    add_checked("0x1p1f", KIND_FAIL, RADIX_DEC, 64'd0, E_DIGIT_EXPONENT, 16'd5);
    add_checked("1.2.3", KIND_FAIL, RADIX_DEC, 64'd0, E_DUP_PERIOD, 16'd3);
    add_checked("1e2e3", KIND_FAIL, RADIX_DEC, 64'd0, E_DUP_EXPONENT, 16'd3);
    add_checked("1_e2", KIND_FAIL, RADIX_DEC, 64'd0, E_EXP_AFTER_US, 16'd2);
    add_checked("1_.2", KIND_FAIL, RADIX_DEC, 64'd0, E_SPECIAL_AFTER_US, 16'd2);
    add_checked("1e", KIND_FAIL, RADIX_DEC, 64'd0, E_TRAILING_SPECIAL, 16'd1);
    add_checked("12_", KIND_FAIL, RADIX_DEC, 64'd0, E_TRAILING_US, 16'd2);
    add_checked("1#2", KIND_FAIL, RADIX_DEC, 64'd0, E_INVALID_CHAR, 16'd1);
    add_checked("\377", KIND_FAIL, RADIX_DEC, 64'd0, E_INVALID_CHAR, 16'd0);
    add_checked("1+", KIND_FAIL, RADIX_DEC, 64'd0, E_EXP_SIGN, 16'd1);
    add_predicted("0o777");
    add_predicted("1.5e-3");
    add_predicted("0x1.8p+4");
    add_predicted("0.5");
    add_predicted("0e1");
    add_predicted("1_000");
    add_predicted("1e1a");

    foreach (row_text[k]) begin
      gen_buf.delete();
      for (int i = 0; i < row_text[k].len(); i++)
        append_byte(row_text[k][i]);
      use_typed  = row_typed[k];
      typed_want = row_want[k];
      send_buf();
    end
    use_typed = 1'b0;

    while (random_sent < RANDOM_BYTES) begin
      build_literal();
      random_sent += gen_buf.size();
      send_buf();
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("PASS numeric_literal_scanner_top");
    else
      $display("FAIL numeric_literal_scanner_top");
    $finish;
  end

endmodule
